// ----- rtl/core/tch_pkg.sv -----
// ----------------------------------------------------------------------------
// Tilt-compensated heading package
// Shared constants, CORDIC angle table and payload types for the
// tilt-compensated heading unit.
// ----------------------------------------------------------------------------
package tch_pkg;

  localparam int MAX_STAGES  = 24;
  localparam int ISQRT_STEPS = 20;
  localparam int NORM_STEPS  = 6;
  localparam int CW          = 34;
  localparam int ZW          = 29;

  localparam logic signed [ZW-1:0] PI_Q24      = 29'sd52707179;
  localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
  localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

  localparam logic [23:0] ATAN_TAB [MAX_STAGES] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
  } sample_t;

  typedef struct packed {
    logic [40:0] v;
    logic [40:0] r;
  } isqrt_t;

  function automatic isqrt_t isqrt_step(isqrt_t s, logic [40:0] b);
    isqrt_t o;
    if (s.v >= s.r + b) begin
      o.v = s.v - (s.r + b);
      o.r = (s.r >> 1) + b;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/tch_atan2.sv -----
// ----------------------------------------------------------------------------
// Pipelined atan2
// Vectoring CORDIC with a half-turn fold, a staged normalizing shift and
// rounding to 13 fraction bits, one word accepted every cycle.
// ----------------------------------------------------------------------------
module tch_atan2 #(
  parameter int W      = 60,
  parameter int STAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld_in,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] x_in,
  output logic                vld_out,
  output logic signed [15:0]  angle
);
  import tch_pkg::*;

  localparam int NW = (W + 1 > 32) ? W + 1 : 32;
  localparam int N  = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
  localparam logic signed [NW-1:0] LIM = NW'(2**30);

  logic                 n_vld  [NORM_STEPS+1];
  logic                 n_zero [NORM_STEPS+1];
  logic signed [NW-1:0] n_x    [NORM_STEPS+1];
  logic signed [NW-1:0] n_y    [NORM_STEPS+1];
  logic signed [ZW-1:0] n_z    [NORM_STEPS+1];

  logic                 c_vld  [N+1];
  logic                 c_zero [N+1];
  logic signed [CW-1:0] c_x    [N+1];
  logic signed [CW-1:0] c_y    [N+1];
  logic signed [ZW-1:0] c_z    [N+1];

  logic signed [NW-1:0] xe;
  logic signed [NW-1:0] ye;
  logic signed [ZW-1:0] zr;

  assign xe = NW'(x_in);
  assign ye = NW'(y_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld[0] <= 1'b0;
    end else begin
      n_vld[0] <= vld_in;
    end
    n_zero[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      n_x[0] <= -xe;
      n_y[0] <= -ye;
      n_z[0] <= (y_in >= 0) ? PI_Q24 : -PI_Q24;
    end else begin
      n_x[0] <= xe;
      n_y[0] <= ye;
      n_z[0] <= '0;
    end
  end

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int B = 1 << (NORM_STEPS - 1 - k);
    logic signed [NW-1:0] t;
    logic signed [NW-1:0] u;
    logic                 fits;
    assign t    = n_x[k] >>> (B - 1);
    assign u    = n_y[k] >>> (B - 1);
    assign fits = (t < LIM) && (u < LIM) && (u > -LIM);
    always_ff @(posedge clk) begin
      if (rst) begin
        n_vld[k+1] <= 1'b0;
      end else begin
        n_vld[k+1] <= n_vld[k];
      end
      n_zero[k+1] <= n_zero[k];
      n_z[k+1]    <= n_z[k];
      if (fits) begin
        n_x[k+1] <= n_x[k];
        n_y[k+1] <= n_y[k];
      end else begin
        n_x[k+1] <= n_x[k] >>> B;
        n_y[k+1] <= n_y[k] >>> B;
      end
    end
  end

  assign c_vld[0]  = n_vld[NORM_STEPS];
  assign c_zero[0] = n_zero[NORM_STEPS];
  assign c_x[0]    = CW'(n_x[NORM_STEPS]);
  assign c_y[0]    = CW'(n_y[NORM_STEPS]);
  assign c_z[0]    = n_z[NORM_STEPS];

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [ZW-1:0] da;
    assign da = $signed(ZW'({1'b0, ATAN_TAB[i]}));
    always_ff @(posedge clk) begin
      if (rst) begin
        c_vld[i+1] <= 1'b0;
      end else begin
        c_vld[i+1] <= c_vld[i];
      end
      c_zero[i+1] <= c_zero[i];
      if (c_y[i] >= 0) begin
        c_x[i+1] <= c_x[i] + (c_y[i] >>> i);
        c_y[i+1] <= c_y[i] - (c_x[i] >>> i);
        c_z[i+1] <= c_z[i] + da;
      end else begin
        c_x[i+1] <= c_x[i] - (c_y[i] >>> i);
        c_y[i+1] <= c_y[i] + (c_x[i] >>> i);
        c_z[i+1] <= c_z[i] - da;
      end
    end
  end

  assign zr = (c_z[N] + ZW'(1024)) >>> 11;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= c_vld[N];
    end
    if (c_zero[N]) begin
      angle <= '0;
    end else if (zr > ZW'(PI_Q13)) begin
      angle <= PI_Q13;
    end else if (zr < -ZW'(PI_Q13)) begin
      angle <= -PI_Q13;
    end else begin
      angle <= 16'(zr);
    end
  end

endmodule

// ----- rtl/core/tilt_compensated_heading_unit.sv -----
// ----------------------------------------------------------------------------
// Tilt-compensated heading unit
// Pitch and roll from the accelerometer, then heading from the derotated
// magnetometer, all three by pipelined CORDIC atan2 in Q13 radians.
// ----------------------------------------------------------------------------
// CORDIC_STAGES above 24 are capped at 24.
// Throughput: one word per cycle; busy is never asserted.
// The depth is set by the 20-step square-root chain, the normalizing shift and the CORDIC stages.
// Reset clears only the valid bits; words in flight are dropped.
module tilt_compensated_heading_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  output logic               done,
  output logic signed [14:0] pitch_angle,
  output logic signed [14:0] roll_angle,
  output logic signed [15:0] heading_angle
);
  import tch_pkg::*;

  localparam int NCS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int LAT = 29 + NORM_STEPS + NCS;

  logic        s0_vld;
  sample_t     s0_smp;
  logic        s1_vld;
  sample_t     s1_smp;
  logic [31:0] s1_sqx;
  logic [31:0] s1_sqy;
  logic [31:0] s1_sqz;

  logic    q_vld [ISQRT_STEPS+1];
  sample_t q_smp [ISQRT_STEPS+1];
  isqrt_t  q_sq  [ISQRT_STEPS+1][3];

  logic [19:0] r1;
  logic [19:0] r2;
  logic [19:0] la;

  logic               m1_vld;
  logic signed [15:0] m1_ax, m1_ay, m1_mx, m1_my;
  logic [19:0]        m1_r1, m1_r2, m1_la;
  logic signed [36:0] m1_pa, m1_pd;
  logic signed [31:0] m1_pb, m1_pc, m1_pe;

  logic               m2_vld;
  logic signed [15:0] m2_ax, m2_ay, m2_mx, m2_my;
  logic [19:0]        m2_r1, m2_r2, m2_la;
  logic signed [37:0] m2_xsum;
  logic signed [47:0] m2_t1;
  logic signed [57:0] m2_t2;
  logic signed [52:0] m2_t3;

  logic               m3_vld;
  logic signed [20:0] m3_px, m3_py, m3_rx, m3_ry;
  logic signed [59:0] m3_hx, m3_hy;

  logic               p_vld, r_vld, h_vld;
  logic signed [15:0] p_ang, r_ang, h_ang;
  logic signed [16:0] h_add;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      q_vld[0] <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
      s1_vld <= s0_vld;
      q_vld[0] <= s1_vld;
    end
    s0_smp <= '{ax: accel_x, ay: accel_y, az: accel_z, mx: mag_x, my: mag_y, mz: mag_z};
    s1_smp <= s0_smp;
    s1_sqx <= 32'(s0_smp.ax * s0_smp.ax);
    s1_sqy <= 32'(s0_smp.ay * s0_smp.ay);
    s1_sqz <= 32'(s0_smp.az * s0_smp.az);
    q_smp[0] <= s1_smp;
    q_sq[0][0] <= '{v: 41'(s1_sqy + s1_sqz) << 8, r: '0};
    q_sq[0][1] <= '{v: 41'(s1_sqx + s1_sqz) << 8, r: '0};
    q_sq[0][2] <= '{v: (41'(s1_sqx) + 41'(s1_sqy) + 41'(s1_sqz)) << 8, r: '0};
  end

  for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_isqrt
    localparam logic [40:0] B = 41'(1) << (2 * (ISQRT_STEPS - 1 - j));
    always_ff @(posedge clk) begin
      if (rst) begin
        q_vld[j+1] <= 1'b0;
      end else begin
        q_vld[j+1] <= q_vld[j];
      end
      q_smp[j+1]   <= q_smp[j];
      q_sq[j+1][0] <= isqrt_step(q_sq[j][0], B);
      q_sq[j+1][1] <= isqrt_step(q_sq[j][1], B);
      q_sq[j+1][2] <= isqrt_step(q_sq[j][2], B);
    end
  end

  assign r1 = q_sq[ISQRT_STEPS][0].r[19:0];
  assign r2 = q_sq[ISQRT_STEPS][1].r[19:0];
  assign la = q_sq[ISQRT_STEPS][2].r[19:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
    end else begin
      m1_vld <= q_vld[ISQRT_STEPS];
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
    end
    m1_ax <= q_smp[ISQRT_STEPS].ax;
    m1_ay <= q_smp[ISQRT_STEPS].ay;
    m1_mx <= q_smp[ISQRT_STEPS].mx;
    m1_my <= q_smp[ISQRT_STEPS].my;
    m1_r1 <= r1;
    m1_r2 <= r2;
    m1_la <= la;
    m1_pa <= 37'(q_smp[ISQRT_STEPS].mx) * 37'($signed({1'b0, r1}));
    m1_pb <= 32'(q_smp[ISQRT_STEPS].mz * q_smp[ISQRT_STEPS].ax);
    m1_pc <= 32'(q_smp[ISQRT_STEPS].mx * q_smp[ISQRT_STEPS].ay);
    m1_pd <= 37'(q_smp[ISQRT_STEPS].my) * 37'($signed({1'b0, r2}));
    m1_pe <= 32'(q_smp[ISQRT_STEPS].mz * q_smp[ISQRT_STEPS].ay);

    m2_ax   <= m1_ax;
    m2_ay   <= m1_ay;
    m2_mx   <= m1_mx;
    m2_my   <= m1_my;
    m2_r1   <= m1_r1;
    m2_r2   <= m1_r2;
    m2_la   <= m1_la;
    m2_xsum <= 38'(m1_pa) + (38'(m1_pb) <<< 4);
    m2_t1   <= 48'(m1_pc) * 48'(m1_ax);
    m2_t2   <= 58'(m1_pd) * 58'($signed({1'b0, m1_la}));
    m2_t3   <= 53'(m1_pe) * 53'($signed({1'b0, m1_r1}));

    m3_py <= 21'($signed({m2_ax, 4'b0000}));
    m3_px <= $signed({1'b0, m2_r1});
    m3_ry <= 21'($signed({m2_ay, 4'b0000}));
    m3_rx <= $signed({1'b0, m2_r2});
    if (m2_la == '0) begin
      m3_hx <= 60'(m2_mx);
      m3_hy <= 60'(m2_my);
    end else begin
      m3_hx <= 60'(m2_xsum) * 60'($signed({1'b0, m2_la}));
      m3_hy <= (60'(m2_t1) <<< 8) + 60'(m2_t2) - (60'(m2_t3) <<< 4);
    end
  end

  tch_atan2 #(.W(21), .STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .rst(rst), .vld_in(m3_vld), .y_in(m3_py), .x_in(m3_px),
    .vld_out(p_vld), .angle(p_ang)
  );

  tch_atan2 #(.W(21), .STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .rst(rst), .vld_in(m3_vld), .y_in(m3_ry), .x_in(m3_rx),
    .vld_out(r_vld), .angle(r_ang)
  );

  tch_atan2 #(.W(60), .STAGES(CORDIC_STAGES)) u_head (
    .clk(clk), .rst(rst), .vld_in(m3_vld), .y_in(m3_hy), .x_in(m3_hx),
    .vld_out(h_vld), .angle(h_ang)
  );

  assign h_add = 17'(h_ang) + 17'(HALF_PI_Q13);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_vld;
    end
    if (p_ang > HALF_PI_Q13) begin
      pitch_angle <= 15'(HALF_PI_Q13);
    end else if (p_ang < -HALF_PI_Q13) begin
      pitch_angle <= 15'(-HALF_PI_Q13);
    end else begin
      pitch_angle <= 15'(p_ang);
    end
    if (r_ang > HALF_PI_Q13) begin
      roll_angle <= 15'(HALF_PI_Q13);
    end else if (r_ang < -HALF_PI_Q13) begin
      roll_angle <= 15'(-HALF_PI_Q13);
    end else begin
      roll_angle <= 15'(r_ang);
    end
    if (h_ang > HALF_PI_Q13) begin
      heading_angle <= 16'(h_add - 17'(2 * 25736));
    end else begin
      heading_angle <= 16'(h_add);
    end
  end

  a_units_aligned: assert property (@(posedge clk) disable iff (rst)
    (p_vld == h_vld) && (r_vld == h_vld))
    else $error("atan2 units out of step");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result word missing at expected latency");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868)
             && (roll_angle <= 15'sd12868) && (roll_angle >= -15'sd12868))
    else $error("pitch or roll out of range");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (heading_angle <= 16'sd25736) && (heading_angle > -16'sd25736))
    else $error("heading out of range");

endmodule

// ----- test/tb_tilt_compensated_heading_unit.sv -----
// ----------------------------------------------------------------------------
// Tilt-compensated heading unit testbench
// Drives sample sets with random gaps and checks pitch, roll and heading of
// every result word against a fixed-point model of the CORDIC computation.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_heading_unit;
  import tch_pkg::*;

  localparam int STAGES    = 16;
  localparam int LATENCY   = 35 + STAGES;
  localparam int WATCHDOG  = 5000;
  localparam int N_RANDOM  = 1600;
  localparam int N_DIRECT  = 20;
  localparam longint PI24  = 52707179;
  localparam longint PI13  = 25736;
  localparam longint HPI13 = 12868;
  localparam longint LIMIT = longint'(1) << 30;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic signed [15:0] heading;
  } angles_t;

  typedef struct {
    sample_t s;
    bit      known;
    angles_t a;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0] mag_x = '0, mag_y = '0, mag_z = '0;
  logic done;
  logic signed [14:0] pitch_angle, roll_angle;
  logic signed [15:0] heading_angle;

  angles_t pending_angles[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      timed_out = 1'b0;
  row_t    rows[N_DIRECT];

  tilt_compensated_heading_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

  always #6 clk = ~clk;

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, nx;
    int n;
    z = 0;
    n = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI24 : -PI24;
      x = -x;
      y = -y;
    end
    while (x >= LIMIT || y >= LIMIT || y <= -LIMIT) begin
      x = x >>> 1;
      y = floor_shr(y, 1);
    end
    for (int i = 0; i < n; i++) begin
      if (y >= 0) begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z = z + longint'(ATAN_TAB[i]);
      end else begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z = z - longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    return clip(floor_shr(z + 1024, 11), PI13);
  endfunction

  function automatic angles_t compass_angles(sample_t s);
    longint ax, ay, az, mx, my, mz, r1, r2, la, p, r, h, xs, ys;
    angles_t a;
    ax = s.ax; ay = s.ay; az = s.az;
    mx = s.mx; my = s.my; mz = s.mz;
    r1 = int_sqrt((ay * ay + az * az) << 8);
    r2 = int_sqrt((ax * ax + az * az) << 8);
    la = int_sqrt((ax * ax + ay * ay + az * az) << 8);
    p = clip(cordic_atan2(ax * 16, r1), HPI13);
    r = clip(cordic_atan2(ay * 16, r2), HPI13);
    if (la == 0) begin
      xs = mx;
      ys = my;
    end else begin
      xs = la * (mx * r1 + mz * ax * 16);
      ys = mx * ay * ax * 256 + my * r2 * la - mz * ay * r1 * 16;
    end
    h = cordic_atan2(ys, xs);
    if (h > HPI13) h = h + HPI13 - 2 * PI13;
    else h = h + HPI13;
    a.pitch = p[14:0];
    a.roll = r[14:0];
    a.heading = h[15:0];
    return a;
  endfunction

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(signed'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
    s.mx = rand_axis(); s.my = rand_axis(); s.mz = rand_axis();
    if ($urandom_range(19) == 0) begin
      s.ax = '0; s.ay = '0; s.az = '0;
    end
    if ($urandom_range(19) == 0) begin
      s.mx = '0; s.my = '0; s.mz = '0;
    end
    return s;
  endfunction

  function automatic row_t make_row(sample_t s, bit known, angles_t a);
    row_t r;
    r.s = s;
    r.known = known;
    r.a = a;
    return r;
  endfunction

  function automatic sample_t six(int ax, int ay, int az, int mx, int my, int mz);
    sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.mx = 16'(mx); s.my = 16'(my); s.mz = 16'(mz);
    return s;
  endfunction

  function automatic angles_t angles3(int p, int r, int h);
    angles_t a;
    a.pitch = 15'(p);
    a.roll = 15'(r);
    a.heading = 16'(h);
    return a;
  endfunction

  task automatic gap();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(2);
    if ($urandom_range(3) == 0) n = 0;
    if (n > 0) start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_sample(sample_t s, bit known, angles_t a);
    start <= 1'b1;
    accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
    mag_x <= s.mx; mag_y <= s.my; mag_z <= s.mz;
    do @(posedge clk); while (busy);
    pending_angles.push_back(known ? a : compass_angles(s));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    angles_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (pending_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word");
        end else begin
          e = pending_angles.pop_front();
          if (pitch_angle !== e.pitch || roll_angle !== e.roll
              || heading_angle !== e.heading) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected p=%0d r=%0d h=%0d got p=%0d r=%0d h=%0d",
                       e.pitch, e.roll, e.heading,
                       pitch_angle, roll_angle, heading_angle);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_tilt_compensated_heading_unit: done, errors");
      $finish;
    end
  end

  initial begin
    angles_t none;
    none = angles3(0, 0, 0);
    rows[0]  = make_row(six(0, 0, 0, 0, 0, 0), 1, angles3(0, 0, 12868));
    rows[1]  = make_row(six(0, 0, 0, 1, 0, 0), 0, none);
    rows[2]  = make_row(six(0, 0, 0, 0, 1, 0), 0, none);
    rows[3]  = make_row(six(0, 0, 100, 0, 0, 0), 0, none);
    rows[4]  = make_row(six(0, 0, 0, -1, 0, 0), 0, none);
    rows[5]  = make_row(six(0, 0, 0, 0, -1, 0), 0, none);
    rows[6]  = make_row(six(32767, 0, 0, 5, 5, 5), 0, none);
    rows[7]  = make_row(six(-32768, 0, 0, 5, 5, 5), 0, none);
    rows[8]  = make_row(six(0, 32767, 0, 0, 0, 0), 0, none);
    rows[9]  = make_row(six(0, -32768, 0, 0, 0, 0), 0, none);
    rows[10] = make_row(six(-32768, -32768, -32768, -32768, -32768, -32768), 0, none);
    rows[11] = make_row(six(32767, 32767, 32767, 32767, 32767, 32767), 0, none);
    rows[12] = make_row(six(-32768, 32767, -32768, 32767, -32768, 32767), 0, none);
    rows[13] = make_row(six(0, 0, -32768, 32767, -32768, 0), 0, none);
    rows[14] = make_row(six(1, -1, 1, -1, 1, -1), 0, none);
    rows[15] = make_row(six(0, 0, 0, -32768, 0, 7), 0, none);
    rows[16] = make_row(six(100, 200, -300, 0, 0, 0), 0, none);
    rows[17] = make_row(six(0, 0, 16384, -32768, -1, 0), 0, none);
    rows[18] = make_row(six(-1, -1, -1, 12345, -23456, 3210), 0, none);
    rows[19] = make_row(six(1000, 0, 1000, 0, 0, -32768), 0, none);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) begin
      send_sample(rows[i].s, rows[i].known, rows[i].a);
      if (i % 3 == 0) gap();
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        while (pending_angles.size() != 0) @(negedge clk);
      end
      if (i % 400 >= 100) gap();
      send_sample(rand_sample(), 0, none);
    end
    start <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_tilt_compensated_heading_unit: done, clean");
    end else begin
      $display("tb_tilt_compensated_heading_unit: done, errors");
    end
    $finish;
  end

endmodule
